// File: hw/rtl/dmc_pkg.sv
package dmc_pkg;

    localparam int DMC_LINES       = 16;
    localparam int DMC_BLOCK_BYTES = 4;
    localparam int DMC_MEM_BYTES   = 256;

    localparam int DMC_ADDR_W = 8;
    localparam int DMC_DATA_W = 8;
    localparam int DMC_OP_W   = 2;

    typedef enum logic [DMC_OP_W-1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_PRELOAD = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOOKUP = 7'b0000010,
        ST_FILL   = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_RDWAIT = 7'b0010000,
        ST_UPD    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

endpackage

// File: hw/rtl/dmc_ram.sv
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/dmc_tag_store.sv
module dmc_tag_store #(
    parameter int LINES = dmc_pkg::DMC_LINES,
    parameter int IDX_W = 4,
    parameter int TAG_W = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] idx,
    input  logic [TAG_W-1:0] tag,
    input  logic             upd,
    output logic             hit
);
    import dmc_pkg::*;

    logic             valid_reg [LINES];
    logic [TAG_W-1:0] tag_reg   [LINES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LINES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (upd) begin
            valid_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd) begin
            tag_reg[idx] <= tag;
        end
    end

    assign hit = valid_reg[idx] && (tag_reg[idx] == tag);

endmodule

// File: hw/rtl/direct_mapped_write_through_cache.sv
// Direct-mapped, write-through, write-allocate byte cache with its own byte-wide main memory.
// LINES, BLOCK_BYTES and MEM_BYTES must be powers of two. The block takes one item at a time
// and is not ready while it works on it; the result register lets the next item in while a
// result waits. On the way to the result register, preload and no-op pass lookup and done, a
// read hit lookup, read wait and done, a write hit lookup, update and done; a miss fills and
// drains after lookup, and a write miss then updates. The block is ready again in the cycle
// after the result is registered. The refill reads main memory one byte per cycle through its
// single read port. Main memory must be preloaded before any refill reads it.
module direct_mapped_write_through_cache #(
    parameter int LINES       = dmc_pkg::DMC_LINES,
    parameter int BLOCK_BYTES = dmc_pkg::DMC_BLOCK_BYTES,
    parameter int MEM_BYTES   = dmc_pkg::DMC_MEM_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dmc_pkg::DMC_OP_W-1:0]    s_opcode,
    input  logic [dmc_pkg::DMC_ADDR_W-1:0]  s_addr,
    input  logic [dmc_pkg::DMC_DATA_W-1:0]  s_write_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dmc_pkg::DMC_DATA_W-1:0]  m_read_data,
    output logic                            m_hit
);
    import dmc_pkg::*;

    localparam int OB    = $clog2(BLOCK_BYTES);
    localparam int IB    = $clog2(LINES);
    localparam int MB    = $clog2(MEM_BYTES);
    localparam int TB    = MB - OB - IB;
    localparam int OFF_W = (OB > 0) ? OB : 1;
    localparam int IDX_W = (IB > 0) ? IB : 1;
    localparam int TAG_W = (TB > 0) ? TB : 1;
    localparam int LA_W  = ((OB + IB) > 0) ? (OB + IB) : 1;
    localparam int MA_W  = (MB > 0) ? MB : 1;

    localparam logic [31:0]      MEM_MASK  = 32'(MEM_BYTES - 1);
    localparam logic [31:0]      BB_MASK   = 32'(BLOCK_BYTES - 1);
    localparam logic [31:0]      LN_MASK   = 32'(LINES - 1);
    localparam logic [OFF_W-1:0] LAST_BYTE = OFF_W'(BLOCK_BYTES - 1);

    state_t                state_reg, state_next;
    op_t                   op_reg;
    logic [DMC_ADDR_W-1:0] addr_reg;
    logic [DMC_DATA_W-1:0] wd_reg;
    logic [OFF_W-1:0]      cnt_reg, cnt_next;
    logic                  fill_wr_reg, fill_wr_next;
    logic [OFF_W-1:0]      fill_cnt_reg;
    logic [DMC_DATA_W-1:0] res_data_reg, res_data_next;
    logic                  res_hit_reg, res_hit_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DMC_DATA_W-1:0] m_read_data_reg;
    logic                  m_hit_reg;

    logic [31:0]       a_mem, off_w, idx_w, tag_w;
    logic [OFF_W-1:0]  off_s;
    logic [LA_W-1:0]   line_addr, fill_line_addr;
    logic [MA_W-1:0]   mem_addr, fill_mem_addr;
    logic              tag_hit, tag_upd;
    logic              line_we, mem_we;
    logic [LA_W-1:0]   line_waddr;
    logic [DMC_DATA_W-1:0] line_wdata, line_rdata, mem_rdata;
    logic              accept, out_free;

    assign a_mem = {{(32 - DMC_ADDR_W){1'b0}}, addr_reg} & MEM_MASK;
    assign off_w = a_mem & BB_MASK;
    assign idx_w = (a_mem >> OB) & LN_MASK;
    assign tag_w = a_mem >> (OB + IB);
    assign off_s = OFF_W'(off_w);

    assign line_addr      = LA_W'((idx_w << OB) | off_w);
    assign fill_line_addr = LA_W'((idx_w << OB) | 32'(fill_cnt_reg));
    assign mem_addr       = MA_W'(a_mem);
    assign fill_mem_addr  = MA_W'(((a_mem >> OB) << OB) | 32'(cnt_reg));

    dmc_tag_store #(
        .LINES (LINES),
        .IDX_W (IDX_W),
        .TAG_W (TAG_W)
    ) u_tags (
        .aclk    (aclk),
        .aresetn (aresetn),
        .idx     (IDX_W'(idx_w)),
        .tag     (TAG_W'(tag_w)),
        .upd     (tag_upd),
        .hit     (tag_hit)
    );

    dmc_ram #(
        .WIDTH (DMC_DATA_W),
        .DEPTH (LINES * BLOCK_BYTES)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_addr),
        .rdata (line_rdata)
    );

    dmc_ram #(
        .WIDTH (DMC_DATA_W),
        .DEPTH (MEM_BYTES)
    ) u_main_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (wd_reg),
        .raddr (fill_mem_addr),
        .rdata (mem_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // refill writes land in the cycle after their main-memory read
    assign line_we    = fill_wr_reg || (state_reg == ST_UPD);
    assign line_waddr = fill_wr_reg ? fill_line_addr : line_addr;
    assign line_wdata = fill_wr_reg ? mem_rdata : wd_reg;
    assign mem_we     = (state_reg == ST_UPD)
                     || ((state_reg == ST_LOOKUP) && (op_reg == OP_PRELOAD));
    assign tag_upd    = (state_reg == ST_DRAIN);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        fill_wr_next  = 1'b0;
        res_data_next = res_data_reg;
        res_hit_next  = res_hit_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (fill_wr_reg && (fill_cnt_reg == off_s)) begin
            res_data_next = mem_rdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                res_hit_next = 1'b0;
                case (op_reg)
                    OP_PRELOAD: begin
                        res_data_next = wd_reg;
                        state_next    = ST_DONE;
                    end
                    OP_READ, OP_WRITE: begin
                        res_hit_next = tag_hit;
                        if (!tag_hit) begin
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end else if (op_reg == OP_WRITE) begin
                            state_next = ST_UPD;
                        end else begin
                            state_next = ST_RDWAIT;
                        end
                    end
                    default: begin
                        res_data_next = '0;
                        state_next    = ST_DONE;
                    end
                endcase
            end
            ST_FILL: begin
                fill_wr_next = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_BYTE) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = (op_reg == OP_WRITE) ? ST_UPD : ST_DONE;
            end
            ST_RDWAIT: begin
                res_data_next = line_rdata;
                state_next    = ST_DONE;
            end
            ST_UPD: begin
                res_data_next = wd_reg;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_wr_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_wr_reg <= fill_wr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= op_t'(s_opcode);
            addr_reg <= s_addr;
            wd_reg   <= s_write_data;
        end
        cnt_reg      <= cnt_next;
        fill_cnt_reg <= cnt_reg;
        res_data_reg <= res_data_next;
        res_hit_reg  <= res_hit_next;
        if ((state_reg == ST_DONE) && out_free) begin
            m_read_data_reg <= res_data_reg;
            m_hit_reg       <= res_hit_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_hit       = m_hit_reg;

endmodule

// File: tb/testbench.sv
module testbench;
    import dmc_pkg::*;

    localparam int PHASE_ITEMS = 382;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [DMC_DATA_W-1:0] data;
        logic                  hit;
    } cache_result_t;

    typedef struct packed {
        op_t                   op;
        logic [DMC_ADDR_W-1:0] addr;
        logic [DMC_DATA_W-1:0] wdata;
        logic                  typed;
        logic [DMC_DATA_W-1:0] rdata;
        logic                  hit;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [DMC_OP_W-1:0]   s_opcode = OP_NOP;
    logic [DMC_ADDR_W-1:0] s_addr = '0;
    logic [DMC_DATA_W-1:0] s_write_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DMC_DATA_W-1:0] m_read_data;
    logic                  m_hit;

    direct_mapped_write_through_cache dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_addr      (s_addr),
        .s_write_data(s_write_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_hit       (m_hit)
    );

    always #6 aclk = ~aclk;

    // shadow copy of the cache and its backing memory
    bit                    shadow_valid [DMC_LINES];
    logic [1:0]            shadow_tag   [DMC_LINES];
    logic [DMC_DATA_W-1:0] shadow_line  [DMC_LINES*DMC_BLOCK_BYTES];
    logic [DMC_DATA_W-1:0] shadow_mem   [DMC_MEM_BYTES];
    bit                    mem_written  [DMC_MEM_BYTES];

    cache_result_t due_results[$];
    int            fail_cnt = 0;
    int            sender_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          hold_go = 1'b0;
    logic          hold_ack = 1'b0;
    int            hold_left = 0;
    int            quiet_cycles = 0;
    logic [DMC_ADDR_W-1:0] hot_base = '0;

    stim_row_t directed_rows [0:23] = '{
        '{OP_PRELOAD, 8'd0,   8'h00, 1'b1, 8'h00, 1'b0},
        '{OP_PRELOAD, 8'd1,   8'h11, 1'b1, 8'h11, 1'b0},
        '{OP_PRELOAD, 8'd2,   8'h22, 1'b1, 8'h22, 1'b0},
        '{OP_PRELOAD, 8'd3,   8'hFF, 1'b1, 8'hFF, 1'b0},
        '{OP_READ,    8'd0,   8'h00, 1'b1, 8'h00, 1'b0},
        '{OP_READ,    8'd3,   8'h00, 1'b1, 8'hFF, 1'b1},
        '{OP_WRITE,   8'd2,   8'hA5, 1'b1, 8'hA5, 1'b1},
        '{OP_READ,    8'd2,   8'h00, 1'b0, 8'h00, 1'b0},
        // preload leaves the cached copy stale
        '{OP_PRELOAD, 8'd1,   8'h5A, 1'b1, 8'h5A, 1'b0},
        '{OP_READ,    8'd1,   8'h00, 1'b1, 8'h11, 1'b1},
        '{OP_NOP,     8'd255, 8'hFF, 1'b1, 8'h00, 1'b0},
        '{OP_PRELOAD, 8'd252, 8'h00, 1'b1, 8'h00, 1'b0},
        '{OP_PRELOAD, 8'd253, 8'hFF, 1'b1, 8'hFF, 1'b0},
        '{OP_PRELOAD, 8'd254, 8'h55, 1'b1, 8'h55, 1'b0},
        '{OP_PRELOAD, 8'd255, 8'hAA, 1'b1, 8'hAA, 1'b0},
        '{OP_WRITE,   8'd255, 8'h00, 1'b1, 8'h00, 1'b0},
        '{OP_READ,    8'd252, 8'h00, 1'b0, 8'h00, 1'b0},
        '{OP_PRELOAD, 8'd64,  8'h80, 1'b1, 8'h80, 1'b0},
        '{OP_PRELOAD, 8'd65,  8'h7F, 1'b1, 8'h7F, 1'b0},
        '{OP_PRELOAD, 8'd66,  8'h01, 1'b1, 8'h01, 1'b0},
        '{OP_PRELOAD, 8'd67,  8'hFE, 1'b1, 8'hFE, 1'b0},
        // same line index, other tag: evicts line 0
        '{OP_READ,    8'd65,  8'h00, 1'b1, 8'h7F, 1'b0},
        '{OP_WRITE,   8'd66,  8'h3C, 1'b0, 8'h00, 1'b0},
        '{OP_READ,    8'd1,   8'h00, 1'b1, 8'h5A, 1'b0}
    };

    function automatic cache_result_t predict_item(op_t op, logic [7:0] a, logic [7:0] wd);
        cache_result_t res;
        logic [3:0]    idx;
        logic [1:0]    tg;
        bit            found;
        res = '0;
        idx = a[5:2];
        tg = a[7:6];
        case (op)
            OP_PRELOAD: begin
                shadow_mem[a] = wd;
                mem_written[a] = 1'b1;
                res.data = wd;
            end
            OP_READ, OP_WRITE: begin
                found = shadow_valid[idx] && shadow_tag[idx] == tg;
                if (!found) begin
                    for (int i = 0; i < DMC_BLOCK_BYTES; i++)
                        shadow_line[{idx, 2'(i)}] = shadow_mem[{a[7:2], 2'(i)}];
                    shadow_valid[idx] = 1'b1;
                    shadow_tag[idx] = tg;
                end
                if (op == OP_WRITE) begin
                    shadow_line[{idx, a[1:0]}] = wd;
                    shadow_mem[a] = wd;
                    mem_written[a] = 1'b1;
                end
                res.data = shadow_line[{idx, a[1:0]}];
                res.hit = found;
            end
            default: ;
        endcase
        return res;
    endfunction

    // a refill must never read memory that was never written
    function automatic bit refill_is_safe(logic [7:0] a);
        bit ok;
        ok = shadow_valid[a[5:2]] && shadow_tag[a[5:2]] == a[7:6];
        if (!ok) begin
            ok = 1'b1;
            for (int i = 0; i < DMC_BLOCK_BYTES; i++)
                if (!mem_written[{a[7:2], 2'(i)}]) ok = 1'b0;
        end
        return ok;
    endfunction

    task automatic drive_item(op_t op, logic [7:0] a, logic [7:0] wd,
                              logic typed, cache_result_t typed_res);
        cache_result_t res;
        s_valid <= 1'b1;
        s_opcode <= op;
        s_addr <= a;
        s_write_data <= wd;
        do @(posedge aclk); while (!s_ready);
        res = predict_item(op, a, wd);
        due_results.push_back(typed ? typed_res : res);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic random_item();
        op_t         op;
        logic [7:0]  a;
        logic [7:0]  wd;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 40) op = OP_READ;
        else if (pick < 75) op = OP_WRITE;
        else if (pick < 95) op = OP_PRELOAD;
        else op = OP_NOP;
        if ($urandom_range(99) < 60) a = hot_base | 8'($urandom_range(31));
        else a = 8'($urandom_range(255));
        wd = 8'($urandom_range(255));
        if ((op == OP_READ || op == OP_WRITE) && !refill_is_safe(a)) begin
            op = OP_PRELOAD;
            for (int i = DMC_BLOCK_BYTES - 1; i >= 0; i--)
                if (!mem_written[{a[7:2], 2'(i)}]) a = {a[7:2], 2'(i)};
        end
        drive_item(op, a, wd, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_go != hold_ack) begin
            hold_ack <= hold_go;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cache_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected item: read_data %0h hit %0b", m_read_data, m_hit);
                fail_cnt++;
            end else begin
                want = due_results.pop_front();
                if (m_read_data !== want.data) begin
                    $error("read_data: expected %0h, actual %0h", want.data, m_read_data);
                    fail_cnt++;
                end
                if (m_hit !== want.hit) begin
                    $error("hit: expected %0b, actual %0b", want.hit, m_hit);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        stim_row_t     row;
        cache_result_t typed_res;
        int            idle_tab  [4] = '{0, 77, 0, 14};
        int            stall_tab [4] = '{0, 0, 77, 14};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            typed_res.data = row.rdata;
            typed_res.hit = row.hit;
            drive_item(row.op, row.addr, row.wdata, row.typed, typed_res);
        end
        wait_drained();
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = idle_tab[phase];
            recv_stall_pct = stall_tab[phase];
            hot_base = 8'($urandom_range(255)) & 8'hE0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 0 && n == 50) hold_go <= ~hold_go;
                random_item();
            end
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0 && due_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: direct_mapped_write_through_cache.f
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_ram.sv
hw/rtl/dmc_tag_store.sv
hw/rtl/direct_mapped_write_through_cache.sv
tb/testbench.sv
